[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

[rtl/fgnk_pkg.sv]
// shared types, constants and saturation helper for the navigation update core
// no dependencies
`timescale 1ns / 1ps

package fgnk_pkg;

    localparam int FracBitsDefault = 16;
    localparam int StateFields = 5;
    localparam int GainEntries = StateFields * StateFields;
    localparam int QWidth = 32;
    localparam int DtWidth = 17;
    localparam int ActWidth = 5;

    localparam logic [ActWidth-1:0] ACT_UPDATE = 5'd0;

    // request into the serial multiplier
    typedef struct packed {
        logic                     start;
        logic signed [QWidth-1:0] a;
        logic signed [QWidth-1:0] b;
    } fgnk_mul_req_t;

    // response from the serial multiplier
    typedef struct packed {
        logic                       done;
        logic signed [2*QWidth-1:0] product;
    } fgnk_mul_rsp_t;

    // clamp a wide sum into the signed 32-bit range
    function automatic logic signed [QWidth-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] vmax;
        logic signed [63:0] vmin;
        vmax = 64'sd2147483647;
        vmin = -64'sd2147483648;
        if (v > vmax) begin
            sat32 = 32'sh7fffffff;
        end else if (v < vmin) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[QWidth-1:0];
        end
    endfunction

endpackage

[rtl/fgnk_mul.sv]
// radix-16 digit-serial signed multiplier, 32 x 32 to exact 64-bit product
// depends on fgnk_pkg
`timescale 1ns / 1ps

module fgnk_mul (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fgnk_pkg::fgnk_mul_req_t req,
    output fgnk_pkg::fgnk_mul_rsp_t rsp
);
    import fgnk_pkg::*;

    localparam int Digits = QWidth / 4;

    logic signed [QWidth-1:0] a_reg, a_next;
    logic [QWidth-1:0]        b_reg, b_next;
    logic signed [37:0]       hi_reg, hi_next;
    logic [QWidth-1:0]        lo_reg, lo_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic signed [4:0]  dig;
    logic signed [36:0] partial;
    logic signed [37:0] sum;

    // current digit, the top one carries the sign of b
    always_comb begin
        if (cnt_reg == 3'(Digits - 1)) begin
            dig = $signed({b_reg[3], b_reg[3:0]});
        end else begin
            dig = $signed({1'b0, b_reg[3:0]});
        end
        partial = a_reg * dig;
        sum = hi_reg + {partial[36], partial};
    end

    // shift-add step
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_next = req.a;
            b_next = req.b;
            hi_next = '0;
            lo_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next = sum >>> 4;
            lo_next = {sum[3:0], lo_reg[QWidth-1:4]};
            b_next = b_reg >> 4;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'(Digits - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.product = {hi_reg[QWidth-1:0], lo_reg};

endmodule

[rtl/fixed_gain_nav_kalman_update_core.sv]
// top level of the fixed-gain navigation update core
// depends on fgnk_pkg and fgnk_mul
`timescale 1ns / 1ps

// an update transaction takes 27 products on one digit-serial multiplier, each a load,
// eight digit steps and an accumulate, plus an innovation step and an output step; a
// gain write or unused code goes straight to the output step. one item at a time: the
// input reopens in the same cycle that the result is offered, and the output step
// waits while a waiting result holds the output register.
// synchronous active-low reset: estimate zero, gains 0.01, time step 0.1 s.
module fixed_gain_nav_kalman_update_core #(
    parameter int FRAC_BITS = fgnk_pkg::FracBitsDefault
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config: time_step
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fgnk_pkg::DtWidth-1:0]      cfg_data,
    // tdata from bit 0: ins_disp_x, ins_disp_y, ins_dvel_x, ins_dvel_y, ins_yaw,
    // meas_pos_x, meas_pos_y, meas_vel_x, meas_vel_y, meas_heading, gain_value
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [351:0]                      s_tdata,
    // tuser: action
    input  logic [fgnk_pkg::ActWidth-1:0]     s_tuser,
    // tdata from bit 0: est_pos_x, est_pos_y, est_vel_x, est_vel_y, est_heading
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [159:0]                      m_tdata
);
    import fgnk_pkg::*;

    localparam logic [63:0] GainReset64 = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] DtReset64 = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic signed [QWidth-1:0] GainReset = GainReset64[QWidth-1:0];
    localparam logic [DtWidth-1:0] DtReset = DtReset64[DtWidth-1:0];
    localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PRED = 5'b00010,
        S_ERR  = 5'b00100,
        S_CORR = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [DtWidth-1:0]       dt_reg;
    logic signed [QWidth-1:0] est_reg   [StateFields];
    logic signed [QWidth-1:0] pred_reg  [StateFields];
    logic signed [QWidth-1:0] err_reg   [StateFields];
    logic signed [QWidth-1:0] meas_reg  [StateFields];
    logic signed [QWidth-1:0] disp_reg  [2];
    logic signed [QWidth-1:0] gain_reg  [GainEntries];
    logic signed [63:0]       acc_reg;
    logic [2:0]               row_reg;
    logic [2:0]               col_reg;
    logic [4:0]               gidx_reg;
    logic                     wait_reg;
    logic                     m_valid_reg;
    logic [159:0]             m_data_reg;

    fgnk_mul_req_t mreq;
    fgnk_mul_rsp_t mrsp;

    logic               accept;
    logic               row_last;
    logic signed [63:0] rounded;
    logic signed [63:0] pos_sum;
    logic signed [63:0] corr_sum;
    logic               out_free;

    fgnk_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free = !m_valid_reg || m_tready;
    assign row_last = (col_reg == 3'(StateFields - 1));

    // product rounding and the two sums fed from the multiplier
    always_comb begin
        rounded = (mrsp.product + Half) >>> FRAC_BITS;
        pos_sum = 64'(est_reg[{2'b00, row_reg[0]}]) + rounded + 64'(disp_reg[row_reg[0]]);
        corr_sum = acc_reg + rounded;
    end

    // multiplier operand selection
    always_comb begin
        mreq.start = 1'b0;
        mreq.a = est_reg[3'd2 + {2'b00, row_reg[0]}];
        mreq.b = $signed({{(QWidth-DtWidth){1'b0}}, dt_reg});
        if (state_reg == S_CORR) begin
            mreq.a = gain_reg[gidx_reg];
            mreq.b = err_reg[col_reg];
        end
        if ((state_reg == S_PRED || state_reg == S_CORR) && !wait_reg) begin
            mreq.start = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == ACT_UPDATE) ? S_PRED : S_DONE;
                end
            end
            S_PRED: begin
                if (mrsp.done && row_reg[0]) begin
                    state_next = S_ERR;
                end
            end
            S_ERR: state_next = S_CORR;
            S_CORR: begin
                if (mrsp.done && row_last && row_reg == 3'(StateFields - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dt_reg <= DtReset;
            wait_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            row_reg <= '0;
            col_reg <= '0;
            gidx_reg <= '0;
            for (int k = 0; k < StateFields; k++) begin
                est_reg[k] <= '0;
            end
            for (int k = 0; k < GainEntries; k++) begin
                gain_reg[k] <= GainReset;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                dt_reg <= cfg_data;
            end
            // output register: load a new result or retire the taken one
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (mreq.start) begin
                wait_reg <= 1'b1;
            end else if (mrsp.done) begin
                wait_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    row_reg <= '0;
                    col_reg <= '0;
                    gidx_reg <= '0;
                    if (accept && s_tuser != ACT_UPDATE
                        && s_tuser <= ActWidth'(GainEntries)) begin
                        gain_reg[s_tuser - 5'd1] <= s_tdata[351:320];
                    end
                end
                S_PRED: begin
                    if (mrsp.done) begin
                        row_reg <= row_reg[0] ? 3'd0 : 3'd1;
                    end
                end
                S_CORR: begin
                    if (mrsp.done) begin
                        gidx_reg <= gidx_reg + 5'd1;
                        if (row_last) begin
                            est_reg[row_reg] <= sat32(corr_sum);
                            col_reg <= '0;
                            row_reg <= row_reg + 3'd1;
                        end else begin
                            col_reg <= col_reg + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && accept) begin
            disp_reg[0] <= s_tdata[31:0];
            disp_reg[1] <= s_tdata[63:32];
            pred_reg[2] <= sat32(64'(est_reg[2]) + 64'($signed(s_tdata[95:64])));
            pred_reg[3] <= sat32(64'(est_reg[3]) + 64'($signed(s_tdata[127:96])));
            pred_reg[4] <= sat32(64'(est_reg[4]) + 64'($signed(s_tdata[159:128])));
            for (int k = 0; k < StateFields; k++) begin
                meas_reg[k] <= s_tdata[160 + 32*k +: 32];
            end
        end
        // position prediction
        if (state_reg == S_PRED && mrsp.done) begin
            pred_reg[{2'b00, row_reg[0]}] <= sat32(pos_sum);
        end
        // innovation
        if (state_reg == S_ERR) begin
            for (int k = 0; k < StateFields; k++) begin
                err_reg[k] <= sat32(64'(meas_reg[k]) - 64'(pred_reg[k]));
            end
            acc_reg <= 64'(pred_reg[0]);
        end
        // correction accumulate
        if (state_reg == S_CORR && mrsp.done) begin
            if (row_last) begin
                if (row_reg != 3'(StateFields - 1)) begin
                    acc_reg <= 64'(pred_reg[row_reg + 3'd1]);
                end
            end else begin
                acc_reg <= corr_sum;
            end
        end
        // result capture
        if (state_reg == S_DONE && out_free) begin
            for (int k = 0; k < StateFields; k++) begin
                m_data_reg[32*k +: 32] <= est_reg[k];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

endmodule

[rtl/fgnk_checker.sv]
// port-level checker for the navigation update core, with its bind
// depends on assert_macros.svh and fixed_gain_nav_kalman_update_core
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fgnk_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         cfg_ready,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);
    // one transaction in flight: input side closes after an accept
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // config is never back-pressured
    `ASSERT_SAME(a_cfg_ready, aclk, aresetn, 1'b1, cfg_ready)
    // stalled result stays offered
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // stalled result data holds
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind fixed_gain_nav_kalman_update_core fgnk_checker u_fgnk_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

[test/tb_top.sv]
// self-checking testbench for the fixed-gain navigation update core
// depends on fgnk_pkg and fixed_gain_nav_kalman_update_core
`timescale 1ns / 1ps

module tb_top;
    import fgnk_pkg::*;

    typedef struct {
        logic [ActWidth-1:0] action;
        logic [351:0]        payload;
    } nav_item_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [16:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [351:0] s_tdata;
    logic [4:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;

    nav_item_t     pending_items[$];
    logic [159:0]  expected_estimates[$];
    logic signed [63:0] nav_est[StateFields];
    logic signed [63:0] nav_gain[GainEntries];
    logic [16:0]   nav_dt;
    int            mismatch_count;
    int            cycle_count;
    int            rx_hold;
    bit            no_idle;
    bit            tx_pause;
    int            tx_gap;
    int            rx_gap;
    int            tx_offered;
    int            tx_accepted;

    fixed_gain_nav_kalman_update_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // rounded q16.16 product, ties toward plus infinity
    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic logic signed [63:0] fld(input logic [351:0] d, input int k);
        return 64'(signed'(d[k*32 +: 32]));
    endfunction

    // advance the estimator by one item and return the packed estimate
    function automatic logic [159:0] predict_estimate(input nav_item_t it);
        logic signed [63:0] pred[StateFields];
        logic signed [63:0] err[StateFields];
        logic signed [63:0] acc;
        logic [159:0]       r;
        if (it.action == ACT_UPDATE) begin
            pred[0] = clamp32(nav_est[0] + qmul(nav_est[2], 64'(nav_dt)) + fld(it.payload, 0));
            pred[1] = clamp32(nav_est[1] + qmul(nav_est[3], 64'(nav_dt)) + fld(it.payload, 1));
            pred[2] = clamp32(nav_est[2] + fld(it.payload, 2));
            pred[3] = clamp32(nav_est[3] + fld(it.payload, 3));
            pred[4] = clamp32(nav_est[4] + fld(it.payload, 4));
            for (int i = 0; i < StateFields; i++)
                err[i] = clamp32(fld(it.payload, 5 + i) - pred[i]);
            for (int i = 0; i < StateFields; i++) begin
                acc = pred[i];
                for (int j = 0; j < StateFields; j++)
                    acc += qmul(nav_gain[i*StateFields + j], err[j]);
                nav_est[i] = clamp32(acc);
            end
        end else if (it.action <= GainEntries) begin
            nav_gain[it.action - 1] = fld(it.payload, 10);
        end
        for (int i = 0; i < StateFields; i++)
            r[i*32 +: 32] = nav_est[i][31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    // input driver: an offered transaction stays on the bus until accepted
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || tx_accepted == tx_offered) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                    tx_gap = $urandom_range(0, 4);
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0 && !tx_pause) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_items[0].action;
                    s_tdata <= pending_items[0].payload;
                    tx_offered++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // expectations are formed at acceptance so config changes land in order
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_estimates.push_back(predict_estimate('{s_tuser, s_tdata}));
            void'(pending_items.pop_front());
            tx_accepted++;
        end
    end

    // result ready with random stalls and long hold-offs
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic [159:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_estimates.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
            end else begin
                want = expected_estimates.pop_front();
                for (int i = 0; i < StateFields; i++)
                    if (m_tdata[i*32 +: 32] !== want[i*32 +: 32])
                        report_mismatch($sformatf("estimate field %0d", i),
                                        m_tdata[i*32 +: 32], want[i*32 +: 32]);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 3000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic nav_item_t rand_item(input int mode);
        nav_item_t it;
        for (int k = 0; k < 11; k++) begin
            case ($urandom_range(0, 5))
                0: it.payload[k*32 +: 32] = 32'h7fffffff;
                1: it.payload[k*32 +: 32] = 32'h80000000;
                2: it.payload[k*32 +: 32] = $urandom;
                default: it.payload[k*32 +: 32] = 32'($signed($urandom_range(0, 1310720))
                                                      - 655360);
            endcase
        end
        // gain values mostly modest so the estimate stays off the rails
        if ($urandom_range(0, 3) != 0)
            it.payload[320 +: 32] = 32'($signed($urandom_range(0, 131072)) - 65536);
        if (mode == 0)
            it.action = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(1, 31)) : ACT_UPDATE;
        else
            it.action = 5'(mode);
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_estimates.size() > 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_time_step(input logic [16:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        nav_dt = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        nav_item_t it;
        logic [16:0] dts[4];
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        rx_hold = 0;
        no_idle = 0;
        tx_pause = 0;
        tx_gap = 0;
        rx_gap = 0;
        tx_offered = 0;
        tx_accepted = 0;
        for (int i = 0; i < StateFields; i++) nav_est[i] = 0;
        for (int i = 0; i < GainEntries; i++) nav_gain[i] = 655;
        nav_dt = 17'd6554;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset gains, extremes, odd-numbered gain slots, unused codes
        it.action = ACT_UPDATE;
        it.payload = '0;
        pending_items.push_back(it);
        it.payload = {11{32'h7fffffff}};
        pending_items.push_back(it);
        pending_items.push_back(it);
        it.payload = {11{32'h80000000}};
        pending_items.push_back(it);
        pending_items.push_back(it);
        for (int k = 1; k <= 31; k += 2) pending_items.push_back(rand_item(k));
        wait_drained();

        // drain before each time step write, then a long receiver hold-off
        dts = '{17'd0, 17'd65536, 17'd6554, 17'd1};
        for (int ph = 0; ph < 4; ph++) begin
            write_time_step(ph == 3 ? 17'($urandom_range(0, 65536)) : dts[ph]);
            if (ph == 1) rx_hold = 1500;
            if (ph == 3) no_idle = 1;
            for (int n = 0; n < 320; n++) pending_items.push_back(rand_item(0));
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/fgnk_pkg.sv
rtl/fgnk_mul.sv
rtl/fixed_gain_nav_kalman_update_core.sv
rtl/fgnk_checker.sv
test/tb_top.sv
